FILE: sv/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types, constants and helpers for the signed decimal formatter
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    localparam int NDIG          = 20;            // bcd digits held per value
    localparam int DIG_W         = NDIG * 4;
    localparam int NDIG_W        = $clog2(NDIG + 1);
    localparam int LONG_BITS     = 64;
    localparam int SHORT_BITS    = 16;
    localparam int CONV_CNT_W    = $clog2(LONG_BITS + 1);
    localparam int IN_DATA_W     = 80;
    localparam int OUT_DATA_W    = 16;
    localparam int FIFO_DEPTH_DEF = 2;
    localparam int MAX_WIDTH_DEF = 63;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // one classified and converted item, handed from front to back
    typedef struct packed {
        logic [DIG_W-1:0]  digits;     // bcd, least significant digit lowest
        logic [NDIG_W-1:0] ndig;       // significant digit count, 0 for zero
        logic [5:0]        prec;       // effective precision
        logic [5:0]        width;
        logic              left;
        logic              has_sign;
        logic [7:0]        sign_char;
    } fmt_desc_t;

    // one shift-add-3 step of the binary to bcd conversion
    function automatic logic [DIG_W-1:0] dabble_step(input logic [DIG_W-1:0] bcd,
                                                     input logic             bit_in);
        logic [DIG_W-1:0] adj;
        logic [3:0]       d;
        adj = bcd;
        for (int k = 0; k < NDIG; k++) begin
            d = bcd[k*4 +: 4];
            if (d >= 4'd5) begin
                adj[k*4 +: 4] = d + 4'd3;
            end
        end
        return {adj[DIG_W-2:0], bit_in};
    endfunction

endpackage

`default_nettype wire

FILE: sv/signed_decimal_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_formatter
// printf style %d text of a signed 64 or 16 bit value, one ascii char per beat
// ----------------------------------------------------------------------------
// order: accept, bit-serial conversion, enqueue, then pop and layout in the back,
//   then the first character in the output register
// the front takes no new item until it has converted and enqueued the last, bound by
//   the bit-serial bcd converter; the back lays out each item before its characters
// the two halves overlap through the queue
// reset: synchronous, active low; clears the control fsms, queue and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_formatter #(
    parameter int MAX_WIDTH  = sdf_pkg::MAX_WIDTH_DEF,   // cap on characters per item
    parameter int FIFO_DEPTH = sdf_pkg::FIFO_DEPTH_DEF   // items between front and back
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input transaction
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // value[63:0], field_width[69:64], min_digits[75:70], has_precision[76],
    // left_align[77], force_plus[78], space_sign[79]
    input  wire logic [sdf_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[0]
    input  wire logic [0:0]                     s_tuser,
    // result transaction, one per character
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_char[7:0], char_count[13:8], zero[15:14]
    output logic [sdf_pkg::OUT_DATA_W-1:0]      m_tdata,
    // char_valid[0]
    output logic [0:0]                          m_tuser,
    // last
    output logic                                m_tlast
);
    import sdf_pkg::*;

    logic      push_valid;
    fmt_desc_t push_desc;
    logic      fifo_full;
    logic      fifo_empty;
    logic      pop;
    fmt_desc_t head;

    // front: sign and precision choice, bit-serial binary to bcd
    sdf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .fifo_full  (fifo_full)
    );

    // queue of converted items so conversion runs ahead of character output
    sdf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_desc (push_desc),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .empty     (fifo_empty)
    );

    // back: text layout and the registered output stage
    sdf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: sv/sdf_front.sv
// ----------------------------------------------------------------------------
// sdf_front
// accepts items, picks sign and precision, converts the magnitude to bcd
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sdf_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic [0:0]                       s_tuser,
    output logic                                  push_valid,
    output sdf_pkg::fmt_desc_t                    push_desc,
    input  wire logic                             fifo_full
);
    import sdf_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [LONG_BITS-1:0]  mag_reg, mag_next;
    logic [DIG_W-1:0]      bcd_reg, bcd_next;
    logic [CONV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [5:0]            prec_reg, prec_next;
    logic [5:0]            width_reg, width_next;
    logic                  left_reg, left_next;
    logic                  has_sign_reg, has_sign_next;
    logic [7:0]            sign_char_reg, sign_char_next;

    logic [LONG_BITS-1:0]  val_sel;
    logic [LONG_BITS-1:0]  mag_in;
    logic                  neg;
    logic [NDIG_W-1:0]     ndig;

    always_comb begin
        val_sel = s_tuser[0] ? {{(LONG_BITS-SHORT_BITS){s_tdata[SHORT_BITS-1]}},
                                s_tdata[SHORT_BITS-1:0]}
                             : s_tdata[LONG_BITS-1:0];
        neg     = val_sel[LONG_BITS-1];
        mag_in  = neg ? (~val_sel + 64'd1) : val_sel;
    end

    // highest nonzero digit gives the digit count
    always_comb begin
        ndig = '0;
        for (int k = 0; k < NDIG; k++) begin
            if (bcd_reg[k*4 +: 4] != 4'd0) begin
                ndig = NDIG_W'(k + 1);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        prec_next      = prec_reg;
        width_next     = width_reg;
        left_next      = left_reg;
        has_sign_next  = has_sign_reg;
        sign_char_next = sign_char_reg;
        push_valid     = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    bcd_next   = '0;
                    width_next = s_tdata[69:64];
                    prec_next  = s_tdata[76] ? s_tdata[75:70] : 6'd1;
                    left_next  = s_tdata[77];
                    if (s_tuser[0]) begin
                        mag_next = {mag_in[SHORT_BITS-1:0], {(LONG_BITS-SHORT_BITS){1'b0}}};
                        cnt_next = CONV_CNT_W'(SHORT_BITS);
                    end else begin
                        mag_next = mag_in;
                        cnt_next = CONV_CNT_W'(LONG_BITS);
                    end
                    if (neg) begin
                        has_sign_next  = 1'b1;
                        sign_char_next = CH_MINUS;
                    end else if (s_tdata[78]) begin
                        has_sign_next  = 1'b1;
                        sign_char_next = CH_PLUS;
                    end else if (s_tdata[79]) begin
                        has_sign_next  = 1'b1;
                        sign_char_next = CH_SPACE;
                    end else begin
                        has_sign_next  = 1'b0;
                        sign_char_next = CH_SPACE;
                    end
                    state_next = F_CONV;
                end
            end
            F_CONV: begin
                bcd_next = dabble_step(bcd_reg, mag_reg[LONG_BITS-1]);
                mag_next = {mag_reg[LONG_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CONV_CNT_W'(1);
                if (cnt_reg == CONV_CNT_W'(1)) begin
                    state_next = F_DONE;
                end
            end
            F_DONE: begin
                if (!fifo_full) begin
                    push_valid = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb begin
        push_desc.digits    = bcd_reg;
        push_desc.ndig      = ndig;
        push_desc.prec      = prec_reg;
        push_desc.width     = width_reg;
        push_desc.left      = left_reg;
        push_desc.has_sign  = has_sign_reg;
        push_desc.sign_char = sign_char_reg;
    end

    assign s_tready = (state_reg == F_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        cnt_reg       <= cnt_next;
        prec_reg      <= prec_next;
        width_reg     <= width_next;
        left_reg      <= left_next;
        has_sign_reg  <= has_sign_next;
        sign_char_reg <= sign_char_next;
    end

endmodule

`default_nettype wire

FILE: sv/sdf_fifo.sv
// ----------------------------------------------------------------------------
// sdf_fifo
// short show-ahead queue of converted items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_fifo #(
    parameter int DEPTH = sdf_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire sdf_pkg::fmt_desc_t push_desc,
    output logic                    full,
    input  wire logic               pop,
    output sdf_pkg::fmt_desc_t      head,
    output logic                    empty
);
    import sdf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmt_desc_t         mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sdf_back.sv
// ----------------------------------------------------------------------------
// sdf_back
// lays out pads, sign, zeros and digits and emits one character per cycle while the receiver is ready
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_back #(
    parameter int MAX_WIDTH = sdf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           fifo_empty,
    input  wire sdf_pkg::fmt_desc_t             head,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sdf_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast
);
    import sdf_pkg::*;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_SETUP = 2'd1;
    localparam logic [1:0] B_EMIT  = 2'd2;
    localparam int         P_W     = 7;
    localparam int         LIMIT   = (MAX_WIDTH > 64) ? 64 : MAX_WIDTH;

    logic [1:0]   state_reg, state_next;
    fmt_desc_t    desc_reg, desc_next;
    logic [P_W-1:0] b1_reg, b1_next, b2_reg, b2_next, b3_reg, b3_next, b4_reg, b4_next;
    logic [P_W-1:0] len_reg, len_next, pos_reg, pos_next;

    logic         m_valid_reg, m_valid_next;
    logic [7:0]   m_char_reg, m_char_next;
    logic         m_cvalid_reg, m_cvalid_next;
    logic         m_last_reg, m_last_next;
    logic [5:0]   m_count_reg, m_count_next;

    logic [P_W-1:0] nd, pr, body, zcnt, pad, tot, dpos;
    logic [NDIG_W-1:0] didx;
    logic [3:0]   digit;
    logic [7:0]   ch;
    logic         advance;

    // layout boundaries from the registered item
    always_comb begin
        nd   = P_W'(desc_reg.ndig);
        pr   = P_W'(desc_reg.prec);
        body = ((nd > pr) ? nd : pr) + P_W'(desc_reg.has_sign);
        zcnt = (pr > nd) ? (pr - nd) : '0;
        pad  = (P_W'(desc_reg.width) > body) ? (P_W'(desc_reg.width) - body) : '0;
        tot  = pad + body;
    end

    // character at the current position
    always_comb begin
        dpos  = b4_reg - P_W'(1) - pos_reg;
        didx  = dpos[NDIG_W-1:0];
        digit = desc_reg.digits[didx*4 +: 4];
        if (pos_reg < b1_reg) begin
            ch = CH_SPACE;
        end else if (pos_reg < b2_reg) begin
            ch = desc_reg.sign_char;
        end else if (pos_reg < b3_reg) begin
            ch = CH_ZERO;
        end else if (pos_reg < b4_reg) begin
            ch = CH_ZERO | {4'd0, digit};
        end else begin
            ch = CH_SPACE;
        end
    end

    assign advance = !m_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        desc_next     = desc_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        b3_next       = b3_reg;
        b4_next       = b4_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_cvalid_next = m_cvalid_reg;
        m_last_next   = m_last_reg;
        m_count_next  = m_count_reg;
        pop           = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!fifo_empty) begin
                    pop        = 1'b1;
                    desc_next  = head;
                    state_next = B_SETUP;
                end
            end
            B_SETUP: begin
                b1_next    = desc_reg.left ? '0 : pad;
                b2_next    = (desc_reg.left ? '0 : pad) + P_W'(desc_reg.has_sign);
                b3_next    = (desc_reg.left ? '0 : pad) + P_W'(desc_reg.has_sign) + zcnt;
                b4_next    = (desc_reg.left ? '0 : pad) + P_W'(desc_reg.has_sign) + zcnt + nd;
                len_next   = (tot > P_W'(LIMIT)) ? P_W'(LIMIT) : tot;
                pos_next   = '0;
                state_next = B_EMIT;
            end
            B_EMIT: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    if (len_reg == '0) begin
                        m_char_next   = 8'd0;
                        m_cvalid_next = 1'b0;
                        m_last_next   = 1'b1;
                        m_count_next  = 6'd0;
                        state_next    = B_IDLE;
                    end else begin
                        m_char_next   = ch;
                        m_cvalid_next = 1'b1;
                        pos_next      = pos_reg + P_W'(1);
                        if (pos_reg + P_W'(1) == len_reg) begin
                            m_last_next  = 1'b1;
                            m_count_next = len_reg[5:0];
                            state_next   = B_IDLE;
                        end else begin
                            m_last_next  = 1'b0;
                            m_count_next = 6'd0;
                        end
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_char_reg};
    assign m_tuser  = m_cvalid_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        desc_reg     <= desc_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        b3_reg       <= b3_next;
        b4_reg       <= b4_next;
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        m_char_reg   <= m_char_next;
        m_cvalid_reg <= m_cvalid_next;
        m_last_reg   <= m_last_next;
        m_count_reg  <= m_count_next;
    end

endmodule

`default_nettype wire

FILE: sv/sdf_checker.sv
// ----------------------------------------------------------------------------
// sdf_checker
// port level checks on the formatter output stream
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // empty marker is a lone last beat with zero data
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 16'd0))
        else $error("bad empty marker");

    // count only on the last beat
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[13:8] == 6'd0))
        else $error("count on a non-final character");

    // only sign, space and digit characters appear
    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[7:0] == 8'h20) || (m_tdata[7:0] == 8'h2b)
                                   || (m_tdata[7:0] == 8'h2d)
                                   || ((m_tdata[7:0] >= 8'h30) && (m_tdata[7:0] <= 8'h39)))
        else $error("unexpected character");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: test/sdf_text_checker.sv
// ----------------------------------------------------------------------------
// sdf_text_checker
// watches both streams of the signed decimal formatter, builds the expected
// printf style text for every accepted value and compares each character beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sdf_text_checker #(
    parameter int MAX_WIDTH = sdf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [sdf_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [0:0]                    s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [sdf_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic [0:0]                    m_tuser,
    input  wire logic                          m_tlast,
    output int                                 fail_count,
    output int                                 pending
);
    import sdf_pkg::*;

    localparam int TEXT_LIMIT = (MAX_WIDTH > 64) ? 64 : MAX_WIDTH;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
        logic [5:0] count;
    } char_beat_t;

    char_beat_t expected_chars[$];
    char_beat_t oldest;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // text of one value: pad, sign, zeros, digits, pad
    task automatic format_decimal(input logic short_mode, input logic [63:0] raw,
                                  input logic [5:0] width, input logic [5:0] min_dig,
                                  input logic has_prec, input logic left,
                                  input logic plus, input logic space);
        logic [63:0] v;
        logic [63:0] mag;
        logic [7:0]  digs[$];
        logic [7:0]  text[$];
        logic [7:0]  sign_ch;
        logic        has_sign;
        int          prec;
        int          body;
        int          n;
        char_beat_t  beat;
        v   = short_mode ? {{48{raw[15]}}, raw[15:0]} : raw;
        mag = v[63] ? (~v + 64'd1) : v;
        while (mag != 64'd0) begin
            digs.push_back(CH_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
        end
        prec     = has_prec ? int'(min_dig) : 1;
        has_sign = 1'b1;
        sign_ch  = CH_MINUS;
        if (!v[63]) begin
            if (plus)       sign_ch = CH_PLUS;
            else if (space) sign_ch = CH_SPACE;
            else            has_sign = 1'b0;
        end
        body = ((digs.size() > prec) ? digs.size() : prec) + (has_sign ? 1 : 0);
        if (!left)
            for (int i = body; i < int'(width); i++) text.push_back(CH_SPACE);
        if (has_sign) text.push_back(sign_ch);
        for (int i = digs.size(); i < prec; i++) text.push_back(CH_ZERO);
        for (int i = digs.size() - 1; i >= 0; i--) text.push_back(digs[i]);
        if (left)
            for (int i = body; i < int'(width); i++) text.push_back(CH_SPACE);
        n = (text.size() > TEXT_LIMIT) ? TEXT_LIMIT : text.size();
        if (n == 0) begin
            beat = '{ch: 8'h00, valid: 1'b0, last: 1'b1, count: 6'd0};
            expected_chars.push_back(beat);
        end else begin
            for (int i = 0; i < n; i++) begin
                beat.ch    = text[i];
                beat.valid = 1'b1;
                beat.last  = (i == n - 1);
                beat.count = (i == n - 1) ? 6'(n) : 6'd0;
                expected_chars.push_back(beat);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                format_decimal(s_tuser[0], s_tdata[63:0], s_tdata[69:64], s_tdata[75:70],
                               s_tdata[76], s_tdata[77], s_tdata[78], s_tdata[79]);
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("character beat 0x%0h with nothing expected", m_tdata);
                    fail_count++;
                end else begin
                    oldest = expected_chars.pop_front();
                    check_field("out_char", oldest.ch, m_tdata[7:0]);
                    check_field("char_count", 8'(oldest.count), 8'(m_tdata[13:8]));
                    check_field("tdata padding", 8'd0, 8'(m_tdata[15:14]));
                    check_field("char_valid", 8'(oldest.valid), 8'(m_tuser[0]));
                    check_field("last", 8'(oldest.last), 8'(m_tlast));
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

FILE: test/tb_signed_decimal_formatter.sv
// ----------------------------------------------------------------------------
// tb_signed_decimal_formatter
// drives values and format flags into the formatter, first a directed set of
// corner cases, then random phases with and without back pressure; a checker
// beside the block predicts every character and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_signed_decimal_formatter;
    import sdf_pkg::*;

    // slowest run is roughly 210 items of up to 63 chars each under heavy stall
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 47;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    // idle percentages for the sender and the receiver, set per phase
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int fail_count;
    int pending;
    int cycles = 0;

    // 12 ns period
    always #6 aclk = ~aclk;

    signed_decimal_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sdf_text_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver side: ready drops at random according to the phase's stall rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        cycles   <= cycles + 1;
    end

    // watchdog on the cycle counter
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one input transaction; an optional idle gap first, then hold valid until taken
    task automatic send_value(input logic short_mode, input logic [63:0] value,
                              input logic [5:0] width, input logic [5:0] min_dig,
                              input logic has_prec, input logic left,
                              input logic plus, input logic space);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < snd_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        // space_sign, force_plus, left_align, has_precision, min_digits, width, value
        s_tdata  <= {space, plus, left, has_prec, min_dig, width, value};
        s_tuser  <= short_mode;
        // ready is stable at the falling edge, the transaction lands at the next rise
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // sender holds off until every predicted character has come out
    task automatic drain_text();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // values biased toward digit-count boundaries and the extremes
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p10;
        int          k;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: begin
                p10 = 64'd1;
                k   = $urandom_range(0, 19);
                repeat (k) p10 = p10 * 64'd10;
                v = p10 - 64'($urandom_range(0, 1));
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 64'h8000_0000_0000_0000;
                    1: v = 64'h7fff_ffff_ffff_ffff;
                    2: v = 64'd0;
                    default: v = '1;
                endcase
            end
            4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = {$urandom, 16'h0000, 16'($urandom)};
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    // random format: mostly narrow widths and precisions, sometimes the full range
    task automatic send_random();
        logic [5:0] width;
        logic [5:0] min_dig;
        width   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 12));
        min_dig = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 62))
                                              : 6'($urandom_range(0, 8));
        send_value($urandom_range(0, 2) == 0, pick_value(), width, min_dig,
                   1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial begin
        // reset held once, at the start
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corner cases, no idling
        //         short  value                     wid    prec   hasp  left  plus  space
        send_value(1'b0, 64'd0,                     6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        // zero with precision 0: no digits, empty marker
        send_value(1'b0, 64'd0,                     6'd0,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0);
        send_value(1'b0, 64'd0,                     6'd0,  6'd0,  1'b1, 1'b0, 1'b1, 1'b0);
        send_value(1'b0, 64'd0,                     6'd5,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0);
        send_value(1'b0, 64'd0,                     6'd3,  6'd0,  1'b1, 1'b1, 1'b0, 1'b1);
        // most negative and most positive long values
        send_value(1'b0, 64'h8000_0000_0000_0000,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        send_value(1'b0, 64'h7fff_ffff_ffff_ffff,   6'd0,  6'd0,  1'b0, 1'b0, 1'b1, 1'b0);
        send_value(1'b0, 64'hffff_ffff_ffff_ffff,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        // plus wins over space, negative ignores both
        send_value(1'b0, 64'd42,                    6'd0,  6'd0,  1'b0, 1'b0, 1'b1, 1'b1);
        send_value(1'b0, 64'd42,                    6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b1);
        send_value(1'b0, -64'd42,                   6'd0,  6'd0,  1'b0, 1'b0, 1'b1, 1'b1);
        // width counts the sign and the zeros, on either side
        send_value(1'b0, -64'd123,                  6'd10, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0);
        send_value(1'b0, -64'd123,                  6'd10, 6'd5,  1'b1, 1'b0, 1'b0, 1'b0);
        send_value(1'b0, 64'd123,                   6'd10, 6'd5,  1'b1, 1'b1, 1'b0, 1'b1);
        // precision ignored without the period
        send_value(1'b0, 64'd7,                     6'd0,  6'd40, 1'b0, 1'b0, 1'b0, 1'b0);
        // short mode: upper bits dropped, bit 15 is the sign
        send_value(1'b1, 64'h0000_0001_2345_8000,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        send_value(1'b1, 64'hdead_beef_cafe_7fff,   6'd8,  6'd0,  1'b0, 1'b1, 1'b1, 1'b0);
        send_value(1'b1, 64'hffff_ffff_ffff_0001,   6'd0,  6'd3,  1'b1, 1'b0, 1'b0, 1'b1);
        send_value(1'b1, 64'h8000_0000_0000_ffff,   6'd6,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        send_value(1'b1, 64'h1234_5678_9abc_0000,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0);
        // longest texts: full width and full precision
        send_value(1'b0, 64'd7,                     6'd63, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0);
        send_value(1'b0, 64'd7,                     6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        send_value(1'b0, 64'd0,                     6'd63, 6'd62, 1'b1, 1'b0, 1'b1, 1'b0);
        send_value(1'b0, 64'h8000_0000_0000_0000,   6'd63, 6'd62, 1'b1, 1'b1, 1'b0, 1'b0);
        send_value(1'b1, 64'h0000_0000_0000_8000,   6'd63, 6'd61, 1'b1, 1'b0, 1'b0, 1'b0);
        drain_text();

        // random phases; every phase ends with the sender waiting for all text
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 54; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 54; end
                default: begin snd_idle_pct = 33; rcv_stall_pct = 33; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random();
            drain_text();
        end

        // let anything still in flight come out
        repeat (150) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
sv/sdf_pkg.sv
sv/sdf_front.sv
sv/sdf_fifo.sv
sv/sdf_back.sv
sv/signed_decimal_formatter.sv
sv/sdf_checker.sv
test/sdf_text_checker.sv
test/tb_signed_decimal_formatter.sv
